FILE: design/wds_pkg.sv
// Shared types, constants and tables of the wave dispersion solver.
package wds_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 24;
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned DIV_DW = 60;
  localparam int unsigned DIV_QW = 40;

  localparam logic [1:0] REG_GRAVITY = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

  localparam logic [19:0] GRAVITY_RST = 20'd642908;
  localparam logic [15:0] TOLERANCE_RST = 16'd168;
  localparam logic [5:0] ITER_LIMIT_RST = 6'd50;

  localparam logic [1:0] STAT_CONVERGED = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_ZERO_FREQ = 2'd2;
  localparam logic [1:0] STAT_ZERO_DEPTH = 2'd3;

  localparam logic [39:0] X_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [39:0] TANH_SAT = 40'd9 << 24;
  localparam logic [24:0] ONE_Q24 = 25'd1 << 24;
  localparam logic [35:0] ONE_Q30 = 36'd1 << 30;
  localparam logic [34:0] LN2_Q30 = 35'd744261118;
  localparam logic [31:0] K_MAX = 32'hFFFF_FFFF;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_A, S_X0C, S_X0D, S_ITER, S_RED, S_CK, S_CR, S_TE, S_TD,
    S_M1, S_M2, S_M3, S_M4, S_M5, S_DEN, S_UPD0, S_UD, S_UPD, S_KC, S_KD, S_DONE
  } state_e;

  typedef struct packed {
    logic [DIV_DW:0]   rem0;
    logic [DIV_QW-1:0] low;
    logic [5:0]        cnt;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  function automatic logic [31:0] atanh_q30(input int i);
    longint unsigned sum;
    int k;
    sum = 0;
    for (k = 1; k * i <= 60; k += 2) begin
      sum += (64'd1 << (60 - k * i)) / 64'(k);
    end
    return 32'((sum + 64'd536870912) >> 30);
  endfunction

  localparam logic [31:0] ATANH_TAB [32] = '{
    32'd0, atanh_q30(1), atanh_q30(2), atanh_q30(3), atanh_q30(4), atanh_q30(5),
    atanh_q30(6), atanh_q30(7), atanh_q30(8), atanh_q30(9), atanh_q30(10),
    atanh_q30(11), atanh_q30(12), atanh_q30(13), atanh_q30(14), atanh_q30(15),
    atanh_q30(16), atanh_q30(17), atanh_q30(18), atanh_q30(19), atanh_q30(20),
    atanh_q30(21), atanh_q30(22), atanh_q30(23), atanh_q30(24), atanh_q30(25),
    atanh_q30(26), atanh_q30(27), atanh_q30(28), atanh_q30(29), atanh_q30(30),
    atanh_q30(31)
  };

endpackage

FILE: design/wds_if.sv
// Valid/ready channel interfaces for solver requests and results.
interface wds_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] omega;
  logic [15:0] depth;
  modport source (output valid, output omega, output depth, input ready);
  modport sink (input valid, input omega, input depth, output ready);
endinterface

interface wds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] wavenumber;
  logic [1:0]  status;
  modport source (output valid, output wavenumber, output status, input ready);
  modport sink (input valid, input wavenumber, input status, output ready);
endinterface

FILE: design/wds_div.sv
// Bit-serial restoring divider shared by all quotient steps of the solver.
module wds_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  wds_pkg::div_req_t       req_i,
  output logic                    done_o,
  output logic [wds_pkg::DIV_QW-1:0] quot_o
);
  import wds_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [5:0]        cnt_q;
  logic [DIV_DW:0]   rem_q;
  logic [DIV_QW-1:0] low_q;
  logic [DIV_QW-1:0] quot_q;
  logic [DIV_DW-1:0] den_q;
  logic [DIV_DW+1:0] rem_sh;
  logic              fits;

  assign rem_sh = {rem_q, low_q[DIV_QW-1]};
  assign fits = rem_sh >= {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= req_i.cnt;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= req_i.rem0;
      low_q <= req_i.low;
      den_q <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      low_q <= {low_q[DIV_QW-2:0], 1'b0};
      if (fits) begin
        rem_q <= (DIV_DW+1)'(rem_sh - {2'b00, den_q});
        quot_q <= {quot_q[DIV_QW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DIV_DW:0];
        quot_q <= {quot_q[DIV_QW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: design/wave_dispersion_solver_top.sv
// Newton solver for the linear water-wave dispersion relation, with APB registers.
//
//   channel  dir  beat                       handshake
//   in_i     in   omega Q4.16, depth 1/64 m  valid/ready
//   out_o    out  wavenumber Q8.24, status   valid/ready
//   apb      in   gravity, tolerance, limit  psel/penable, pready tied high
//
// Each Newton step evaluates tanh(x) with the iterative CORDIC rotator after a range
// reduction 2x = n*ln2 + r, n = floor(2x/ln2) <= 25, and skips both once x >= 9; the
// quotients come from the shared bit-serial divider. Zero depth, frequency or gravity
// skips the solve.
// The input is ready only in idle; a held result stalls only the next completion.
// Reset is asynchronous and restores register defaults.
module wave_dispersion_solver_top #(
  parameter int unsigned CORDIC_STAGES = wds_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  wds_in_if.sink                       in_i,
  wds_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wds_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import wds_pkg::*;

  localparam int unsigned STG_W = $clog2(CORDIC_STAGES);
  localparam logic [STG_W-1:0] STG_LAST = STG_W'(CORDIC_STAGES - 1);

  state_e state_q, state_d;

  logic [19:0] grav_q;
  logic [15:0] tol_q;
  logic [5:0]  lim_q;

  logic [19:0] om_q;
  logic [15:0] dep_q;
  logic [39:0] om2_q;
  logic [43:0] a_q;
  logic [43:0] b_q;
  logic [39:0] x_q;
  logic [5:0]  it_q;
  logic [24:0] t_q;
  logic [34:0] w_q;
  logic [4:0]  n_q;
  logic [35:0] k_q;
  logic [35:0] p_q;
  logic [44:0] den_q;
  logic [43:0] diff_q;
  logic        neg_q;
  logic [39:0] mag_q;
  logic [31:0] res_q;
  logic [1:0]  stat_q;
  logic        ov_q;
  logic [31:0] wn_q;
  logic [1:0]  so_q;

  logic signed [35:0] cx_q, cy_q, cz_q;
  logic signed [35:0] cx_n, cy_n, cz_n, dx, dy, ang;
  logic [4:0]         i_q, i_d;
  logic [6:0]         rep_q, rep_d;
  logic               again_q, again_d;
  logic [STG_W-1:0]   stg_q;
  logic signed [36:0] csum;

  logic [43:0] opa;
  logic [24:0] opb;
  logic [68:0] prod_q;

  logic              div_start, div_done;
  div_req_t          div_req;
  logic [DIV_QW-1:0] quot;

  logic        cfg_wr, in_fire, out_free;
  logic        x0_sat, tanh_sat, e_le, upd_sat, k_sat, conv;
  logic [59:0] e_w;
  logic [41:0] x_sum;
  logic [39:0] xn, xstep;
  logic [47:0] k_num;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire = in_i.valid & in_i.ready;
  assign out_free = !ov_q || out_o.ready;
  assign out_o.valid = ov_q;
  assign out_o.wavenumber = wn_q;
  assign out_o.status = so_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAVITY_RST;
      tol_q <= TOLERANCE_RST;
      lim_q <= ITER_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GRAVITY:    grav_q <= pwdata[19:0];
        REG_TOLERANCE:  tol_q <= pwdata[15:0];
        REG_ITER_LIMIT: lim_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRAVITY:    prdata = {12'd0, grav_q};
      REG_TOLERANCE:  prdata = {16'd0, tol_q};
      REG_ITER_LIMIT: prdata = {26'd0, lim_q};
      default:        prdata = '0;
    endcase
  end

  // Datapath compares
  assign x0_sat = {12'd0, om2_q} >= {grav_q, 32'd0};
  assign tanh_sat = x_q >= TANH_SAT;
  assign e_w = 60'(p_q) << n_q;
  assign e_le = e_w <= 60'(k_q);
  assign upd_sat = (den_q == '0) || ({17'd0, diff_q} >= {den_q, 16'd0});
  assign x_sum = {2'd0, x_q} + {2'd0, mag_q};
  always_comb begin
    if (neg_q) begin
      xn = (x_q > mag_q) ? (x_q - mag_q) : 40'd1;
    end else begin
      xn = (x_sum > {2'd0, X_MAX}) ? X_MAX : x_sum[39:0];
    end
    xstep = (xn >= x_q) ? (xn - x_q) : (x_q - xn);
  end
  assign conv = xstep <= {24'd0, tol_q};
  assign k_num = {2'd0, x_q, 6'd0};
  assign k_sat = k_num >= {dep_q, 32'd0};

  // CORDIC rotation step
  assign dx = cy_q >>> i_q;
  assign dy = cx_q >>> i_q;
  assign ang = $signed({4'd0, ATANH_TAB[i_q]});
  always_comb begin
    if (!cz_q[35]) begin
      cx_n = cx_q + dx;
      cy_n = cy_q + dy;
      cz_n = cz_q - ang;
    end else begin
      cx_n = cx_q - dx;
      cy_n = cy_q - dy;
      cz_n = cz_q + ang;
    end
    i_d = i_q;
    rep_d = rep_q;
    again_d = again_q;
    if ({2'd0, i_q} == rep_q && !again_q) begin
      again_d = 1'b1;
    end else begin
      if ({2'd0, i_q} == rep_q) begin
        rep_d = 7'(rep_q * 7'd3 + 7'd1);
        again_d = 1'b0;
      end
      i_d = i_q + 5'd1;
    end
  end
  assign csum = {cx_n[35], cx_n} + {cy_n[35], cy_n};

  // Shared multiplier operands
  always_comb begin
    opa = '0;
    opb = '0;
    unique case (state_q)
      S_SQ: begin
        opa = 44'(om_q);
        opb = 25'(om_q);
      end
      S_A: begin
        opa = 44'(prod_q[39:0]);
        opb = 25'(dep_q);
      end
      S_M1: begin
        opa = 44'(x_q);
        opb = 25'(grav_q);
      end
      S_M2: begin
        opa = prod_q[59:16];
        opb = t_q;
      end
      S_M3: begin
        opa = 44'(t_q);
        opb = t_q;
      end
      S_M4: begin
        opa = 44'(x_q);
        opb = ONE_Q24 - prod_q[48:24];
      end
      S_M5: begin
        opa = 44'(t_q) + 44'(prod_q[63:24]);
        opb = 25'(grav_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa * opb;
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    div_start = 1'b0;
    div_req = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_i.depth == '0 || in_i.omega == '0 || grav_q == '0) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SQ;
          end
        end
      end
      S_SQ: state_d = S_A;
      S_A: state_d = S_X0C;
      S_X0C: begin
        if (x0_sat) begin
          state_d = S_ITER;
        end else begin
          div_start = 1'b1;
          div_req.rem0 = 61'(om2_q[39:32]);
          div_req.low = {om2_q[31:0], 8'd0};
          div_req.cnt = 6'd40;
          div_req.den = 60'(grav_q);
          state_d = S_X0D;
        end
      end
      S_X0D: if (div_done) state_d = S_ITER;
      S_ITER: begin
        if (it_q == lim_q) begin
          state_d = S_KC;
        end else if (tanh_sat) begin
          state_d = S_M1;
        end else begin
          state_d = S_RED;
        end
      end
      S_RED: if (w_q < LN2_Q30) state_d = S_CK;
      S_CK: if (stg_q == STG_LAST) state_d = S_CR;
      S_CR: if (stg_q == STG_LAST) state_d = S_TE;
      S_TE: begin
        if (e_le) begin
          state_d = S_M1;
        end else begin
          div_start = 1'b1;
          div_req.rem0 = 61'(e_w - 60'(k_q));
          div_req.low = '0;
          div_req.cnt = 6'd24;
          div_req.den = e_w + 60'(k_q);
          state_d = S_TD;
        end
      end
      S_TD: if (div_done) state_d = S_M1;
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: state_d = S_M5;
      S_M5: state_d = S_DEN;
      S_DEN: state_d = S_UPD0;
      S_UPD0: begin
        if (upd_sat) begin
          state_d = S_UPD;
        end else begin
          div_start = 1'b1;
          div_req.rem0 = 61'(diff_q[43:16]);
          div_req.low = {diff_q[15:0], 24'd0};
          div_req.cnt = 6'd40;
          div_req.den = 60'(den_q);
          state_d = S_UD;
        end
      end
      S_UD: if (div_done) state_d = S_UPD;
      S_UPD: state_d = conv ? S_KC : S_ITER;
      S_KC: begin
        if (k_sat) begin
          state_d = S_DONE;
        end else begin
          div_start = 1'b1;
          div_req.rem0 = 61'(k_num[45:32]);
          div_req.low = {k_num[31:0], 8'd0};
          div_req.cnt = 6'd32;
          div_req.den = 60'(dep_q);
          state_d = S_KD;
        end
      end
      S_KD: if (div_done) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        om_q <= in_i.omega;
        dep_q <= in_i.depth;
        if (in_i.depth == '0) begin
          res_q <= K_MAX;
          stat_q <= STAT_ZERO_DEPTH;
        end else if (in_i.omega == '0) begin
          res_q <= '0;
          stat_q <= STAT_ZERO_FREQ;
        end else begin
          res_q <= K_MAX;
          stat_q <= STAT_LIMIT;
        end
      end
      S_A: om2_q <= prod_q[39:0];
      S_X0C: begin
        a_q <= prod_q[57:14];
        it_q <= '0;
        if (x0_sat) x_q <= X_MAX;
      end
      S_X0D: if (div_done) x_q <= (quot == '0) ? 40'd1 : quot;
      S_ITER: begin
        stat_q <= STAT_LIMIT;
        w_q <= {x_q[27:0], 7'd0};
        n_q <= '0;
        if (tanh_sat) t_q <= ONE_Q24;
      end
      S_RED: begin
        if (w_q >= LN2_Q30) begin
          w_q <= w_q - LN2_Q30;
          n_q <= n_q + 5'd1;
        end
        cx_q <= $signed(ONE_Q30);
        cy_q <= '0;
        cz_q <= '0;
        i_q <= 5'd1;
        rep_q <= 7'd4;
        again_q <= 1'b0;
        stg_q <= '0;
      end
      S_CK: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        i_q <= i_d;
        rep_q <= rep_d;
        again_q <= again_d;
        stg_q <= stg_q + 1'b1;
        if (stg_q == STG_LAST) begin
          k_q <= cx_n[35] ? '0 : cx_n;
          cx_q <= $signed(ONE_Q30);
          cy_q <= '0;
          cz_q <= $signed({1'b0, w_q});
          i_q <= 5'd1;
          rep_q <= 7'd4;
          again_q <= 1'b0;
          stg_q <= '0;
        end
      end
      S_CR: begin
        cx_q <= cx_n;
        cy_q <= cy_n;
        cz_q <= cz_n;
        i_q <= i_d;
        rep_q <= rep_d;
        again_q <= again_d;
        stg_q <= stg_q + 1'b1;
        if (stg_q == STG_LAST) p_q <= csum[36] ? '0 : csum[35:0];
      end
      S_TE: if (e_le) t_q <= '0;
      S_TD: if (div_done) t_q <= quot[24:0];
      S_M3: b_q <= prod_q[67:24];
      S_DEN: begin
        den_q <= prod_q[60:16];
        neg_q <= a_q < b_q;
        diff_q <= (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
      end
      S_UPD0: if (upd_sat) mag_q <= X_MAX;
      S_UD: if (div_done) mag_q <= quot;
      S_UPD: begin
        if (conv) begin
          stat_q <= STAT_CONVERGED;
        end else begin
          x_q <= xn;
          it_q <= it_q + 6'd1;
        end
      end
      S_KC: if (k_sat) res_q <= K_MAX;
      S_KD: if (div_done) res_q <= quot[31:0];
      S_DONE: begin
        if (out_free) begin
          wn_q <= res_q;
          so_q <= stat_q;
        end
      end
      default: ;
    endcase
  end

  wds_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quot_o  (quot)
  );

endmodule

FILE: design/wds_check.sv
// Port-level assertions for the solver top level, bound to it.
module wds_check (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] wavenumber_i,
  input logic [1:0]  status_i
);
  import wds_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(wavenumber_i) && $stable(status_i))
    else $error("result beat changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("accepted a beat while solving");

  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_ZERO_DEPTH |-> wavenumber_i == K_MAX)
    else $error("zero depth without saturated wavenumber");

  a_zero_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STAT_ZERO_FREQ |-> wavenumber_i == '0)
    else $error("zero frequency with nonzero wavenumber");

endmodule

bind wave_dispersion_solver_top wds_check u_wds_check (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .wavenumber_i (out_o.wavenumber),
  .status_i     (out_o.status)
);

FILE: sim/wds_checker.sv
// Beat monitor, fixed-point dispersion solver predictor and result scoreboard.
module wds_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  wds_in_if                           req_mon,
  wds_out_if                          res_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wds_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output int                          errors_o,
  output int                          pending_o
);
  import wds_pkg::*;

  typedef struct {
    logic [31:0] wavenumber;
    logic [1:0]  status;
  } solution_t;

  localparam longint unsigned XLIM = 64'(X_MAX);
  localparam longint unsigned UNIT = 64'(ONE_Q24);

  logic [19:0] grav_q;
  logic [15:0] tol_q;
  logic [5:0]  lim_q;
  solution_t   solutions_q[$];
  int          errors;

  assign errors_o  = errors;
  assign pending_o = solutions_q.size();

  function automatic void cordic_rot(input longint z, output longint cx, output longint cy);
    longint x, y, a, dx, dy;
    longint unsigned sum;
    int i, rep, s, kk;
    bit again;
    x = 64'sd1 << 30;
    y = 0;
    i = 1;
    rep = 4;
    again = 0;
    for (s = 0; s < CORDIC_STAGES_DEF; s++) begin
      sum = 0;
      for (kk = 1; kk * i <= 60; kk += 2) sum += (64'd1 << (60 - kk * i)) / 64'(kk);
      a = longint'((sum + (64'd1 << 29)) >> 30);
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x += dx; y += dy; z -= a;
      end else begin
        x -= dx; y -= dy; z += a;
      end
      if (i == rep && !again) begin
        again = 1;
      end else begin
        if (i == rep) begin
          rep = 3 * rep + 1;
          again = 0;
        end
        i++;
      end
    end
    cx = x;
    cy = y;
  endfunction

  function automatic longint unsigned frac_div(input longint unsigned num,
                                               input longint unsigned den,
                                               input longint unsigned maxv);
    longint unsigned q, r;
    int b;
    if (den == 0) return maxv;
    q = num / den;
    if (q > (maxv >> 24)) return maxv;
    r = num % den;
    for (b = 0; b < 24; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r -= den;
        q |= 1;
      end
    end
    return (q > maxv) ? maxv : q;
  endfunction

  function automatic longint unsigned mul_frac(input longint unsigned a,
                                               input longint unsigned t);
    return (a >> 24) * t + (((a & 64'hFF_FFFF) * t) >> 24);
  endfunction

  function automatic longint unsigned tanh_fix(input longint unsigned x);
    longint w, n, r, c, s, kg, d, p;
    longint unsigned e;
    if (x >= 64'(TANH_SAT)) return UNIT;
    w = longint'(x << 7);
    n = w / longint'(LN2_Q30);
    r = w - n * longint'(LN2_Q30);
    cordic_rot(r, c, s);
    p = c + s;
    if (p < 0) p = 0;
    cordic_rot(0, kg, d);
    if (kg < 0) kg = 0;
    e = longint'(p) << n;
    if (e <= longint'(kg)) return 0;
    return frac_div(e - kg, e + kg, UNIT);
  endfunction

  function automatic longint unsigned clamp_x(input longint v);
    if (v < 1) return 1;
    if (longint'(v) > longint'(XLIM)) return XLIM;
    return v;
  endfunction

  function automatic solution_t solve_wavenumber(input logic [19:0] om, input logic [15:0] dep);
    solution_t res;
    longint unsigned g, om2, x, q, t, a, gx, b, sq, den, mag, xn, diff, kw;
    longint stp;
    int it;
    g = grav_q;
    res.status = STAT_LIMIT;
    if (dep == 0) begin
      res.wavenumber = K_MAX; res.status = STAT_ZERO_DEPTH; return res;
    end
    if (om == 0) begin
      res.wavenumber = 0; res.status = STAT_ZERO_FREQ; return res;
    end
    if (g == 0) begin
      res.wavenumber = K_MAX; return res;
    end
    om2 = 64'(om) * 64'(om);
    q = (om2 << 8) / g;
    x = clamp_x((q > XLIM) ? XLIM : q);
    for (it = 0; it < int'(lim_q); it++) begin
      t = tanh_fix(x);
      a = (om2 * 64'(dep)) >> 14;
      gx = (g * x) >> 16;
      b = mul_frac(gx, t);
      sq = UNIT - ((t * t) >> 24);
      den = (g * (t + mul_frac(x, sq))) >> 16;
      if (a >= b) begin
        mag = frac_div(a - b, den, XLIM);
        stp = mag;
      end else begin
        mag = frac_div(b - a, den, XLIM);
        stp = -longint'(mag);
      end
      xn = clamp_x(longint'(x) + stp);
      diff = (xn >= x) ? xn - x : x - xn;
      if (diff <= 64'(tol_q)) begin
        res.status = STAT_CONVERGED;
        break;
      end
      x = xn;
    end
    kw = (x << 6) / 64'(dep);
    res.wavenumber = (kw > 64'(K_MAX)) ? K_MAX : kw[31:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    solution_t want;
    if (!rst_ni) begin
      grav_q <= GRAVITY_RST;
      tol_q  <= TOLERANCE_RST;
      lim_q  <= ITER_LIMIT_RST;
      solutions_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_GRAVITY:    grav_q <= pwdata[19:0];
          REG_TOLERANCE:  tol_q  <= pwdata[15:0];
          REG_ITER_LIMIT: lim_q  <= pwdata[5:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready)
        solutions_q.push_back(solve_wavenumber(req_mon.omega, req_mon.depth));
      if (res_mon.valid && res_mon.ready) begin
        if (solutions_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat wavenumber=%0d status=%0d", $time,
                   res_mon.wavenumber, res_mon.status);
        end else begin
          want = solutions_q.pop_front();
          if (res_mon.wavenumber !== want.wavenumber) begin
            errors++;
            $display("%0t: wavenumber expected %0d actual %0d", $time,
                     want.wavenumber, res_mon.wavenumber);
          end
          if (res_mon.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     res_mon.status);
          end
        end
      end
    end
  end
endmodule

FILE: sim/tb_wave_dispersion_solver_top.sv
// Stimulus and verdict for the wave dispersion solver, with the checker beside the block.
module tb_wave_dispersion_solver_top;
  import wds_pkg::*;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel, penable, pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  int                   errors, pending;
  int                   gap_pct, stall_pct;

  wds_in_if  req_ch();
  wds_out_if res_ch();

  wave_dispersion_solver_top u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(req_ch), .out_o(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  wds_checker u_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_mon(req_ch), .res_mon(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) res_ch.ready <= ($urandom_range(99) >= stall_pct);

  initial begin
    #80_000_000;
    $display("tb_wave_dispersion_solver_top: errors");
    $finish;
  end

  task automatic send_beat(input logic [19:0] om, input logic [15:0] dep);
    req_ch.valid <= 1'b1;
    req_ch.omega <= om;
    req_ch.depth <= dep;
    do @(posedge clk_i); while (!req_ch.ready);
    if ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [19:0] g, input logic [15:0] tol, input logic [5:0] lim);
    reg_write(REG_GRAVITY, 32'(g));
    reg_write(REG_TOLERANCE, 32'(tol));
    reg_write(REG_ITER_LIMIT, 32'(lim));
  endtask

  task automatic random_beats(input int count);
    int n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(2) == 0)
        send_beat(20'($urandom), 16'($urandom));
      else
        send_beat(20'($urandom_range(260000, 13000)), 16'($urandom_range(12800, 32)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.omega = '0;
    req_ch.depth = '0;
    res_ch.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gap_pct = 0;
    stall_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(20'd65536, 16'd0);
    send_beat(20'd0, 16'd640);
    send_beat(20'd0, 16'd0);
    send_beat(20'hFFFFF, 16'hFFFF);
    send_beat(20'hFFFFF, 16'd1);
    send_beat(20'd1, 16'hFFFF);
    send_beat(20'd1, 16'd1);
    send_beat(20'd65536, 16'd640);
    send_beat(20'd6554, 16'd64000);
    send_beat(20'd400000, 16'd6400);
    send_beat(20'd30000, 16'd64);
    send_beat(20'd131072, 16'd3200);
    drain();

    reg_write(2'd3, 32'hFFFF_FFFF);
    configure(20'hFFFFF, 16'hFFFF, 6'd63);
    gap_pct = 85;
    send_beat(20'd65536, 16'd640);
    random_beats(25);
    drain();

    configure(20'd1, 16'd1, 6'd1);
    gap_pct = 0;
    stall_pct = 85;
    send_beat(20'hFFFFF, 16'd1);
    random_beats(25);
    drain();

    configure(GRAVITY_RST, TOLERANCE_RST, ITER_LIMIT_RST);
    gap_pct = 13;
    stall_pct = 13;
    random_beats(30);
    drain();
    random_beats(30);
    drain();

    configure(20'd0, 16'd168, 6'd50);
    gap_pct = 0;
    stall_pct = 0;
    send_beat(20'd65536, 16'd640);
    send_beat(20'd0, 16'd640);
    drain();
    configure(20'd642908, 16'd100, 6'd0);
    send_beat(20'd65536, 16'd640);
    send_beat(20'd200000, 16'd3);
    drain();
    configure(20'd642908, 16'd0, 6'd63);
    random_beats(6);
    configure_tail();
  end

  task automatic configure_tail();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0)
      $display("tb_wave_dispersion_solver_top: clean");
    else
      $display("tb_wave_dispersion_solver_top: errors");
    $finish;
  endtask
endmodule

FILE: filelist.f
design/wds_pkg.sv
design/wds_if.sv
design/wds_div.sv
design/wave_dispersion_solver_top.sv
design/wds_check.sv
sim/wds_checker.sv
sim/tb_wave_dispersion_solver_top.sv
